@@ sv/point_in_polygon_winding_defines.svh @@
// Assertion macros shared by the point-in-polygon winding RTL.
// Depends on nothing; every user module has i_clk and i_rst_n ports.
`ifndef POINT_IN_POLYGON_WINDING_DEFINES_SVH
`define POINT_IN_POLYGON_WINDING_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define PIPW_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define PIPW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/pipw_pkg.sv @@
// Package for the point-in-polygon winding block: widths, edge and beat types.
// No dependencies; used by every module of the block except pipw_fifo.
`default_nettype none

package pipw_pkg;

    localparam int LNG_W  = 32;
    localparam int LAT_W  = 31;
    localparam int DX_W   = LNG_W + 1;   // longitude difference
    localparam int DY_W   = LAT_W + 1;   // latitude difference
    localparam int PROD_W = DX_W + DY_W; // exact cross-product term
    localparam int WIND_W = 17;

    localparam logic signed [WIND_W-1:0] WIND_HI = 17'sh0FFFF;  //  65535
    localparam logic signed [WIND_W-1:0] WIND_LO = 17'sh10000;  // -65536

    localparam int MID_DEPTH_DEF = 4;
    localparam int OUT_DEPTH_DEF = 4;

    // Register index, taken from paddr[2]
    localparam logic REG_QUERY_LNG = 1'b0;
    localparam logic REG_QUERY_LAT = 1'b1;

    typedef enum logic [1:0] {
        DIR_NONE,
        DIR_UP,
        DIR_DOWN
    } t_dir;

    // One classified edge, ready for the cross product
    typedef struct packed {
        t_dir                    dir;
        logic signed [DX_W-1:0]  dx;    // x2 - x1
        logic signed [DY_W-1:0]  dqy;   // query_lat - y1
        logic signed [DX_W-1:0]  dqx;   // query_lng - x1
        logic signed [DY_W-1:0]  dy;    // y2 - y1
    } t_edge;

    // Beat passed from front to back: edge into this vertex, closing edge
    typedef struct packed {
        t_edge open_e;
        t_edge close_e;
        logic  last;
    } t_item;

    typedef struct packed {
        logic                     in_poly;
        logic signed [WIND_W-1:0] winding;
    } t_result;

endpackage

`default_nettype wire

@@ sv/pipw_fifo.sv @@
// Small register FIFO with occupancy count, used between front and back
// and as the result queue. No dependencies beyond the shared assertion macros.
`default_nettype none
`include "point_in_polygon_winding_defines.svh"

module pipw_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_rdata,
    output logic                  o_full,
    output logic                  o_empty,
    output logic      [CW-1:0]    o_count
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wptr, n_wptr;
    logic [PW-1:0]    r_rptr, n_rptr;
    logic [CW-1:0]    r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign o_rdata = r_mem[r_rptr];

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // pointer and count next values
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (do_push) begin
            n_wptr = (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (do_pop) begin
            n_rptr = (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // storage, no reset
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    `PIPW_ASSERT_IMPLY(a_no_overflow, i_push, !o_full, "fifo push while full")
    `PIPW_ASSERT_IMPLY(a_count_bound, 1'b1, r_count <= CW'(DEPTH), "fifo count out of range")

endmodule

`default_nettype wire

@@ sv/pipw_front.sv @@
// Front end: tracks first and previous vertex, classifies both edges of a beat.
// Depends on pipw_pkg.
`default_nettype none

module pipw_front (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_accept,
    input  wire logic signed [pipw_pkg::LNG_W-1:0]   i_vertex_lng,
    input  wire logic signed [pipw_pkg::LAT_W-1:0]   i_vertex_lat,
    input  wire logic                                i_last_vertex,
    input  wire logic signed [pipw_pkg::LNG_W-1:0]   i_query_lng,
    input  wire logic signed [pipw_pkg::LAT_W-1:0]   i_query_lat,
    output pipw_pkg::t_item                          o_item
);

    logic signed [pipw_pkg::LNG_W-1:0] r_first_lng, r_prev_lng;
    logic signed [pipw_pkg::LAT_W-1:0] r_first_lat, r_prev_lat;
    logic                              r_at_start;

    logic signed [pipw_pkg::LNG_W-1:0] first_lng;
    logic signed [pipw_pkg::LAT_W-1:0] first_lat;
    logic                              closes_on_first;

    // Build one edge record; direction is up, down or no crossing
    function automatic pipw_pkg::t_edge make_edge(
        input logic signed [pipw_pkg::LNG_W-1:0] x1,
        input logic signed [pipw_pkg::LAT_W-1:0] y1,
        input logic signed [pipw_pkg::LNG_W-1:0] x2,
        input logic signed [pipw_pkg::LAT_W-1:0] y2,
        input logic signed [pipw_pkg::LNG_W-1:0] qx,
        input logic signed [pipw_pkg::LAT_W-1:0] qy,
        input logic                              en
    );
        pipw_pkg::t_edge e;
        e.dx  = pipw_pkg::DX_W'(x2) - pipw_pkg::DX_W'(x1);
        e.dqy = pipw_pkg::DY_W'(qy) - pipw_pkg::DY_W'(y1);
        e.dqx = pipw_pkg::DX_W'(qx) - pipw_pkg::DX_W'(x1);
        e.dy  = pipw_pkg::DY_W'(y2) - pipw_pkg::DY_W'(y1);
        if (!en) begin
            e.dir = pipw_pkg::DIR_NONE;
        end else if ((y1 <= qy) && (y2 > qy)) begin
            e.dir = pipw_pkg::DIR_UP;
        end else if ((y1 > qy) && (y2 <= qy)) begin
            e.dir = pipw_pkg::DIR_DOWN;
        end else begin
            e.dir = pipw_pkg::DIR_NONE;
        end
        return e;
    endfunction

    // the first vertex of a polygon is its own first point
    assign first_lng = r_at_start ? i_vertex_lng : r_first_lng;
    assign first_lat = r_at_start ? i_vertex_lat : r_first_lat;
    assign closes_on_first = (i_vertex_lng == first_lng) && (i_vertex_lat == first_lat);

    // edge into this vertex and, on the last vertex, the closing edge
    always_comb begin
        o_item.open_e  = make_edge(r_prev_lng, r_prev_lat, i_vertex_lng, i_vertex_lat,
                                   i_query_lng, i_query_lat, !r_at_start);
        o_item.close_e = make_edge(i_vertex_lng, i_vertex_lat, first_lng, first_lat,
                                   i_query_lng, i_query_lat,
                                   i_last_vertex && !closes_on_first);
        o_item.last    = i_last_vertex;
    end

    // polygon tracking state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_at_start  <= 1'b1;
            r_first_lng <= '0;
            r_first_lat <= '0;
            r_prev_lng  <= '0;
            r_prev_lat  <= '0;
        end else if (i_accept) begin
            r_at_start <= i_last_vertex;
            r_prev_lng <= i_vertex_lng;
            r_prev_lat <= i_vertex_lat;
            if (r_at_start) begin
                r_first_lng <= i_vertex_lng;
                r_first_lat <= i_vertex_lat;
            end
        end
    end

endmodule

`default_nettype wire

@@ sv/pipw_back.sv @@
// Back end: cross products of both edges, sign test, saturating winding count.
// Depends on pipw_pkg and the shared assertion macros.
`default_nettype none
`include "point_in_polygon_winding_defines.svh"

module pipw_back #(
    parameter int OUT_DEPTH = pipw_pkg::OUT_DEPTH_DEF,
    localparam int CW       = $clog2(OUT_DEPTH + 1)
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire pipw_pkg::t_item      i_item,
    input  wire logic                 i_item_valid,
    output logic                      o_pop,
    input  wire logic [CW-1:0]        i_out_count,
    output logic                      o_res_push,
    output pipw_pkg::t_result         o_res
);

    // stage 1: registered products
    logic                                  r_s1_v;
    logic                                  r_s1_last;
    pipw_pkg::t_dir                        r_dir_a, r_dir_b;
    logic signed [pipw_pkg::PROD_W-1:0]    r_pa1, r_pa2, r_pb1, r_pb2;

    logic signed [pipw_pkg::WIND_W-1:0]    r_count, n_count;
    logic signed [pipw_pkg::WIND_W-1:0]    count_a, count_b;
    logic signed [pipw_pkg::PROD_W:0]      diff_a, diff_b;
    logic                                  pos_a, neg_a, pos_b, neg_b;
    logic [CW:0]                           occupancy;

    function automatic logic signed [pipw_pkg::WIND_W-1:0] sat_step(
        input logic signed [pipw_pkg::WIND_W-1:0] c,
        input logic                               inc,
        input logic                               dec
    );
        if (inc && (c != pipw_pkg::WIND_HI)) begin
            return c + pipw_pkg::WIND_W'(1);
        end else if (dec && (c != pipw_pkg::WIND_LO)) begin
            return c - pipw_pkg::WIND_W'(1);
        end
        return c;
    endfunction

    // pop only with room in the result queue for everything in flight
    assign occupancy = {1'b0, i_out_count} + (CW + 1)'(r_s1_v);
    assign o_pop     = i_item_valid && (occupancy < (CW + 1)'(OUT_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else begin
            r_s1_v <= o_pop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_last <= i_item.last;
            r_dir_a   <= i_item.open_e.dir;
            r_dir_b   <= i_item.close_e.dir;
            r_pa1     <= i_item.open_e.dx * i_item.open_e.dqy;
            r_pa2     <= i_item.open_e.dqx * i_item.open_e.dy;
            r_pb1     <= i_item.close_e.dx * i_item.close_e.dqy;
            r_pb2     <= i_item.close_e.dqx * i_item.close_e.dy;
        end
    end

    // stage 2: exact sign of each cross product
    assign diff_a = {r_pa1[pipw_pkg::PROD_W-1], r_pa1} - {r_pa2[pipw_pkg::PROD_W-1], r_pa2};
    assign diff_b = {r_pb1[pipw_pkg::PROD_W-1], r_pb1} - {r_pb2[pipw_pkg::PROD_W-1], r_pb2};
    assign neg_a  = diff_a[pipw_pkg::PROD_W];
    assign pos_a  = !neg_a && (diff_a != '0);
    assign neg_b  = diff_b[pipw_pkg::PROD_W];
    assign pos_b  = !neg_b && (diff_b != '0);

    // open edge first, then closing edge, each saturating
    always_comb begin
        count_a = sat_step(r_count, (r_dir_a == pipw_pkg::DIR_UP) && pos_a,
                           (r_dir_a == pipw_pkg::DIR_DOWN) && neg_a);
        count_b = sat_step(count_a, (r_dir_b == pipw_pkg::DIR_UP) && pos_b,
                           (r_dir_b == pipw_pkg::DIR_DOWN) && neg_b);
        n_count = r_count;
        if (r_s1_v) begin
            n_count = r_s1_last ? '0 : count_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // result beat on the last vertex
    assign o_res_push     = r_s1_v && r_s1_last;
    assign o_res.in_poly  = (count_b != '0);
    assign o_res.winding  = count_b;

    `PIPW_ASSERT_IMPLY(a_res_room, o_res_push, i_out_count < CW'(OUT_DEPTH), "result queue overrun")
    `PIPW_ASSERT_NEXT(a_count_cleared, o_res_push, r_count == '0, "count not rearmed after result")

endmodule

`default_nettype wire

@@ sv/point_in_polygon_winding.sv @@
// Point-in-polygon test by winding number.
// Query point is set through an APB-style port: query_lng at byte 0x0, query_lat
// at byte 0x4 (31 bits, sign-extended on read). Write it only while no polygon is
// in progress. Vertices enter on push/full, one beat per vertex, last_vertex set on
// the final one. Each polygon yields one result beat on empty/pop: the signed
// winding count (saturating at -65536/+65535) and inside_res = count nonzero.
// Throughput: one vertex per cycle while the result queue drains; both edges of a
// vertex (incoming and closing) are evaluated in parallel by four 33x32 multipliers.
// The result shows (empty low) after the front queue, the product stage and the
// result queue; the count settles in the same cycle the result is written.
// A 4-entry queue decouples the front classifier from the back arithmetic, and a
// 4-entry result queue lets the receiver stall; the back end stops pulling vertices
// when the result queue could fill, after which full rises on the input side.
// Reset (synchronous, active low) empties both queues, clears the count and the
// query registers, and rearms for the first vertex of a new polygon.
// Depends on pipw_pkg, pipw_fifo, pipw_front, pipw_back.
`default_nettype none
`include "point_in_polygon_winding_defines.svh"

module point_in_polygon_winding #(
    parameter int MID_DEPTH = pipw_pkg::MID_DEPTH_DEF,
    parameter int OUT_DEPTH = pipw_pkg::OUT_DEPTH_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // configuration
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [2:0]                         paddr,
    input  wire logic [31:0]                        pwdata,
    output logic      [31:0]                        prdata,
    output logic                                    pready,
    // vertex input
    input  wire logic                               push,
    output logic                                    full,
    input  wire logic signed [pipw_pkg::LNG_W-1:0]  i_vertex_lng,
    input  wire logic signed [pipw_pkg::LAT_W-1:0]  i_vertex_lat,
    input  wire logic                               i_last_vertex,
    // result output
    output logic                                    empty,
    input  wire logic                               pop,
    output logic                                    o_inside_res,
    output logic signed [pipw_pkg::WIND_W-1:0]      o_winding
);

    localparam int MID_CW = $clog2(MID_DEPTH + 1);
    localparam int OUT_CW = $clog2(OUT_DEPTH + 1);
    localparam int ITEM_W = $bits(pipw_pkg::t_item);
    localparam int RES_W  = $bits(pipw_pkg::t_result);

    logic signed [pipw_pkg::LNG_W-1:0] r_query_lng;
    logic signed [pipw_pkg::LAT_W-1:0] r_query_lat;
    logic                              cfg_wr;
    logic                              accept;

    pipw_pkg::t_item   front_item, back_item;
    logic [ITEM_W-1:0] mid_rdata;
    logic              mid_empty, mid_pop;
    logic [MID_CW-1:0] mid_count;

    pipw_pkg::t_result res_in, res_out;
    logic [RES_W-1:0]  out_rdata;
    logic              res_push, out_full;
    logic [OUT_CW-1:0] out_count;

    // configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_query_lng <= '0;
            r_query_lat <= '0;
        end else if (cfg_wr) begin
            case (paddr[2])
                pipw_pkg::REG_QUERY_LNG: r_query_lng <= pwdata;
                pipw_pkg::REG_QUERY_LAT: r_query_lat <= pwdata[pipw_pkg::LAT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            pipw_pkg::REG_QUERY_LNG: prdata = r_query_lng;
            pipw_pkg::REG_QUERY_LAT: prdata = 32'(r_query_lat);
            default:                 prdata = '0;
        endcase
    end

    // front: classify each vertex beat
    assign accept = push && !full;

    pipw_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_vertex_lng  (i_vertex_lng),
        .i_vertex_lat  (i_vertex_lat),
        .i_last_vertex (i_last_vertex),
        .i_query_lng   (r_query_lng),
        .i_query_lat   (r_query_lat),
        .o_item        (front_item)
    );

    // queue between front and back
    pipw_fifo #(
        .WIDTH (ITEM_W),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_wdata (front_item),
        .i_pop   (mid_pop),
        .o_rdata (mid_rdata),
        .o_full  (full),
        .o_empty (mid_empty),
        .o_count (mid_count)
    );

    assign back_item = mid_rdata;

    // back: cross products and winding count
    pipw_back #(
        .OUT_DEPTH (OUT_DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (back_item),
        .i_item_valid (!mid_empty && (mid_count != '0)),
        .o_pop        (mid_pop),
        .i_out_count  (out_count),
        .o_res_push   (res_push),
        .o_res        (res_in)
    );

    // result queue
    pipw_fifo #(
        .WIDTH (RES_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_wdata (res_in),
        .i_pop   (pop),
        .o_rdata (out_rdata),
        .o_full  (out_full),
        .o_empty (empty),
        .o_count (out_count)
    );

    assign res_out      = out_rdata;
    assign o_inside_res = res_out.in_poly;
    assign o_winding    = res_out.winding;

    `PIPW_ASSERT_IMPLY(a_res_not_full, res_push, !out_full, "result beat into a full queue")

endmodule

`default_nettype wire

@@ dv/tb_point_in_polygon_winding.sv @@
// Self-checking testbench for point_in_polygon_winding: vertex beats in, winding results out.
// A behavioral winding-count tracker predicts each result; depends on pipw_pkg and the RTL.
`timescale 1ns / 1ps

module tb_point_in_polygon_winding;

    localparam int CYCLE_LIMIT = 2500000;
    localparam int LONG_LOOPS  = 10;      // loops in each long polygon
    localparam int RAND_PHASES = 7;
    localparam int PHASE_ITEMS = 60;

    // DUT signals
    logic                               i_clk;
    logic                               i_rst_n;
    logic                               psel;
    logic                               penable;
    logic                               pwrite;
    logic [2:0]                         paddr;
    logic [31:0]                        pwdata;
    logic [31:0]                        prdata;
    logic                               pready;
    logic                               push;
    logic                               full;
    logic signed [pipw_pkg::LNG_W-1:0]  i_vertex_lng;
    logic signed [pipw_pkg::LAT_W-1:0]  i_vertex_lat;
    logic                               i_last_vertex;
    logic                               empty;
    logic                               pop;
    logic                               o_inside_res;
    logic signed [pipw_pkg::WIND_W-1:0] o_winding;

    // Winding tracker state
    longint            qry_lng    = 0;
    longint            qry_lat    = 0;
    longint            start_lng  = 0;
    longint            start_lat  = 0;
    longint            last_lng   = 0;
    longint            last_lat   = 0;
    int                wind       = 0;
    bit                poly_open  = 1'b0;
    pipw_pkg::t_result expected_windings[$];

    // Pacing and bookkeeping
    int cycle_cnt = 0;
    int err_cnt   = 0;
    bit tx_pace   = 1'b0;
    bit rx_pace   = 1'b0;
    int tx_burst  = 0;
    int rx_stall  = 0;
    int rx_hold   = 0;

    point_in_polygon_winding dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .push          (push),
        .full          (full),
        .i_vertex_lng  (i_vertex_lng),
        .i_vertex_lat  (i_vertex_lat),
        .i_last_vertex (i_last_vertex),
        .empty         (empty),
        .pop           (pop),
        .o_inside_res  (o_inside_res),
        .o_winding     (o_winding)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog
    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("Regression FAIL");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH cycle %0d: %s", cycle_cnt, msg);
        err_cnt++;
    endtask

    // Sign of the exact cross product for edge (x1,y1)->(x2,y2) against the query
    function automatic int cross_side(longint x1, longint y1, longint x2, longint y2);
        logic signed [67:0] dx, dqy, dqx, dy, lhs, rhs;
        dx  = x2 - x1;
        dqy = qry_lat - y1;
        dqx = qry_lng - x1;
        dy  = y2 - y1;
        lhs = dx * dqy;
        rhs = dqx * dy;
        return (lhs > rhs) ? 1 : ((lhs < rhs) ? -1 : 0);
    endfunction

    // Upward crossing with point left adds one, downward with point right subtracts one
    function automatic void tally_edge(longint x1, longint y1, longint x2, longint y2);
        if (y1 <= qry_lat) begin
            if (y2 > qry_lat && cross_side(x1, y1, x2, y2) > 0
                && wind < int'(pipw_pkg::WIND_HI))
                wind++;
        end else if (y2 <= qry_lat) begin
            if (cross_side(x1, y1, x2, y2) < 0 && wind > int'(pipw_pkg::WIND_LO))
                wind--;
        end
    endfunction

    // Advance the tracker by one accepted vertex; queue a result on the last one
    function automatic void track_vertex(logic signed [pipw_pkg::LNG_W-1:0] vlng,
                                         logic signed [pipw_pkg::LAT_W-1:0] vlat,
                                         logic last);
        longint            x;
        longint            y;
        pipw_pkg::t_result r;
        x = vlng;
        y = vlat;
        if (!poly_open) begin
            start_lng = x;
            start_lat = y;
            wind      = 0;
            poly_open = 1'b1;
        end else begin
            tally_edge(last_lng, last_lat, x, y);
        end
        last_lng = x;
        last_lat = y;
        if (last) begin
            // closing edge, skipped when the ring is already closed
            if (x != start_lng || y != start_lat)
                tally_edge(x, y, start_lng, start_lat);
            r.in_poly = (wind != 0);
            r.winding = wind[pipw_pkg::WIND_W-1:0];
            expected_windings.push_back(r);
            wind      = 0;
            poly_open = 1'b0;
        end
    endfunction

    // Register write: setup then access
    task automatic apb_write(input logic reg_sel, input logic [31:0] data);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {reg_sel, 2'b00};
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (reg_sel == pipw_pkg::REG_QUERY_LNG)
            qry_lng = longint'($signed(data));
        else
            qry_lat = longint'($signed(data[pipw_pkg::LAT_W-1:0]));
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Query point; the latitude goes out sign-extended to the bus width
    task automatic set_query(input longint lng, input longint lat);
        apb_write(pipw_pkg::REG_QUERY_LNG, 32'(lng));
        apb_write(pipw_pkg::REG_QUERY_LAT, 32'(lat));
    endtask

    // One vertex beat, with bursty gaps when pacing is on
    task automatic send_vertex(input longint lng, input longint lat, input logic last);
        if (tx_pace && tx_burst == 0) begin
            @(negedge i_clk);
            push = 1'b0;
            repeat ($urandom_range(0, 5)) @(negedge i_clk);
            tx_burst = $urandom_range(1, 12);
        end
        @(negedge i_clk);
        push          = 1'b1;
        i_vertex_lng  = pipw_pkg::LNG_W'(lng);
        i_vertex_lat  = pipw_pkg::LAT_W'(lat);
        i_last_vertex = last;
        do @(posedge i_clk); while (full);
        track_vertex(i_vertex_lng, i_vertex_lat, last);
        if (tx_burst > 0)
            tx_burst--;
    endtask

    // Stop offering, let every result come back, then let the pipeline settle
    task automatic wait_idle();
        @(negedge i_clk);
        push = 1'b0;
        while (expected_windings.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    function automatic longint jitter(int spread);
        return longint'($urandom_range(0, 2 * spread)) - spread;
    endfunction

    // Random polygon: mostly vertices scattered around the query, some raw noise
    task automatic send_polygon(output int nverts);
        int     kind;
        int     spread;
        int     i;
        int     pick;
        longint lng;
        longint lng0;
        longint lat;
        longint lat0;
        kind   = $urandom_range(0, 9);
        nverts = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 8);
        case ($urandom_range(0, 2))
            0:       spread = 3;
            1:       spread = 2000;
            default: spread = 1 << 24;
        endcase
        lng0 = 0;
        lat0 = 0;
        for (i = 0; i < nverts; i++) begin
            if (kind == 0) begin
                lng = $urandom;
                lat = $urandom;
            end else begin
                pick = $urandom_range(0, 9);
                if (pick == 1 && i > 0) begin
                    // repeated vertex, zero-length edge
                    lng = last_lng;
                    lat = last_lat;
                end else begin
                    lng = qry_lng + jitter(spread);
                    lat = (pick == 0) ? qry_lat : qry_lat + jitter(spread);
                end
            end
            if (i == 0) begin
                lng0 = lng;
                lat0 = lat;
            end else if (i == nverts - 1 && $urandom_range(0, 3) == 0) begin
                lng = lng0;
                lat = lat0;
            end
            send_vertex(lng, lat, i == nverts - 1);
        end
    endtask

    // Receiver: random stalls, plus a long hold-off counted here
    initial begin
        pop = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold > 0) begin
                pop = 1'b0;
                rx_hold--;
            end else if (!rx_pace) begin
                pop = 1'b1;
            end else if (rx_stall > 0) begin
                pop = 1'b0;
                rx_stall--;
            end else begin
                pop = 1'b1;
                if ($urandom_range(0, 9) < 3)
                    rx_stall = $urandom_range(1, 7);
            end
        end
    end

    // Result checker
    always @(posedge i_clk) begin : chk_result
        pipw_pkg::t_result want;
        if (i_rst_n && pop && !empty) begin
            if (expected_windings.size() == 0) begin
                report_mismatch($sformatf("unexpected result inside=%0b winding=%0d",
                                          o_inside_res, o_winding));
            end else begin
                want = expected_windings.pop_front();
                if (o_inside_res !== want.in_poly)
                    report_mismatch($sformatf("inside_res got %0b want %0b",
                                              o_inside_res, want.in_poly));
                if (o_winding !== want.winding)
                    report_mismatch($sformatf("winding got %0d want %0d",
                                              o_winding, want.winding));
            end
        end
    end

    // Hand-picked polygons: orientation, closure, degenerate and extreme cases
    task automatic test_directed();
        tx_pace = 1'b1;
        rx_pace = 1'b1;
        set_query(0, 0);
        // counterclockwise square around the point
        send_vertex(10, -10, 1'b0);
        send_vertex(10, 10, 1'b0);
        send_vertex(-10, 10, 1'b0);
        send_vertex(-10, -10, 1'b1);
        // clockwise square, ring closed explicitly
        send_vertex(-10, -10, 1'b0);
        send_vertex(-10, 10, 1'b0);
        send_vertex(10, 10, 1'b0);
        send_vertex(10, -10, 1'b0);
        send_vertex(-10, -10, 1'b1);
        // lone vertex: no edge at all
        send_vertex(7, -3, 1'b1);
        // edge through the point and a vertex on the query latitude
        send_vertex(0, -5, 1'b0);
        send_vertex(0, 5, 1'b0);
        send_vertex(-5, 0, 1'b1);
        // full bit-pattern extremes
        send_vertex(32'sh7fffffff, 31'sh40000000, 1'b0);
        send_vertex(32'sh7fffffff, 31'sh3fffffff, 1'b0);
        send_vertex(32'sh80000000, 0, 1'b1);
        // legal range extremes
        send_vertex(1800000000, -900000000, 1'b0);
        send_vertex(-1800000000, 900000000, 1'b0);
        send_vertex(-1800000000, -900000000, 1'b1);
        wait_idle();
        // query in the most negative corner
        set_query(32'sh80000000, 31'sh40000000);
        send_vertex(32'sh7fffffff, 31'sh3fffffff, 1'b0);
        send_vertex(32'sh80000000, 31'sh3fffffff, 1'b0);
        send_vertex(32'sh80000000, 31'sh40000000, 1'b1);
        wait_idle();
    endtask

    // Long polygons that wind the count up several times, then down
    task automatic test_long_polygons();
        int k;
        tx_pace = 1'b0;
        rx_pace = 1'b0;
        set_query(0, 0);
        // each loop: up on the right (+1), back down through the point (no change)
        for (k = 0; k < LONG_LOOPS; k++) begin
            send_vertex(10, -1, 1'b0);
            send_vertex(10, 1, 1'b0);
            send_vertex(-10, -1, k == LONG_LOOPS - 1);
        end
        // mirror: down on the right (-1), back up through the point
        for (k = 0; k < LONG_LOOPS; k++) begin
            send_vertex(10, 1, 1'b0);
            send_vertex(10, -1, 1'b0);
            send_vertex(-10, 1, k == LONG_LOOPS - 1);
        end
        wait_idle();
    endtask

    // Hold results back while vertices keep coming, so full must rise
    task automatic test_backpressure();
        int i;
        int n;
        tx_pace = 1'b0;
        rx_pace = 1'b0;
        rx_hold = 300;
        for (i = 0; i < 24; i++)
            send_polygon(n);
        wait_idle();
    endtask

    // Random polygons over several query settings
    task automatic test_random_polygons();
        int     phase;
        int     sent;
        int     n;
        longint ql;
        longint qa;
        for (phase = 0; phase < RAND_PHASES; phase++) begin
            case (phase)
                0: begin ql = 0;             qa = 0;             end
                1: begin ql = 1800000000;    qa = 900000000;     end
                2: begin ql = -1800000000;   qa = -900000000;    end
                3: begin ql = 32'sh7fffffff; qa = 31'sh3fffffff; end
                4: begin ql = 32'sh80000000; qa = 31'sh40000000; end
                default: begin
                    ql = longint'($urandom_range(0, 32'd3600000000)) - 1800000000;
                    qa = longint'($urandom_range(0, 1800000000)) - 900000000;
                end
            endcase
            wait_idle();
            set_query(ql, qa);
            tx_pace = (phase != 2);
            rx_pace = (phase != 3);
            sent    = 0;
            while (sent < PHASE_ITEMS) begin
                send_polygon(n);
                sent += n;
                if ($urandom_range(0, 15) == 0)
                    wait_idle();
            end
        end
        wait_idle();
    endtask

    // Sequence
    initial begin
        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        push          = 1'b0;
        i_vertex_lng  = '0;
        i_vertex_lat  = '0;
        i_last_vertex = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_backpressure();
        test_random_polygons();
        test_long_polygons();

        wait_idle();
        repeat (20) @(posedge i_clk);
        if (err_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
